[src/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, constants and functions of the beat tone synthesizer: the
// register map, the quarter-wave sine table and the sample rounding helpers.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int PHASE_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int TABLE_BITS = 10;
    localparam int QTR_SIZE   = 256;
    localparam int QTR_BITS   = 8;
    localparam int MAG_W      = SAMPLE_W - 1;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 18;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 33;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_PEAK_Q = 64'd32767;

    typedef enum logic [1:0] {
        MODE_SILENT,
        MODE_BINAURAL,
        MODE_MONAURAL,
        MODE_ISOCHRONIC
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_CARRIER,
        REG_BEAT,
        REG_AMP,
        REG_DUTY
    } reg_idx_t;

    localparam logic [31:0] CARRIER_RST = 32'd19478309;
    localparam logic [31:0] BEAT_RST    = 32'd973915;
    localparam logic [15:0] AMP_RST     = 16'd16384;
    localparam logic [15:0] AMP_MAX     = 16'd32768;
    localparam logic [16:0] DUTY_RST    = 17'd26214;
    localparam logic [16:0] DUTY_MIN    = 17'd655;
    localparam logic [16:0] DUTY_MAX    = 17'd65536;
    localparam logic [16:0] ENV_ONE     = 17'd65536;
    localparam logic [17:0] SMOOTH_K    = 18'd196608;
    localparam logic [DIV_D_W-1:0] PERCENT = DIV_D_W'(100);

    typedef struct packed {
        mode_t             mode;
        logic [31:0]       carrier;
        logic signed [31:0] beat;
        logic [15:0]       amp;
        logic [16:0]       duty;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_D_W-1:0] quot;
    } div_rsp_t;

    typedef logic [MAG_W-1:0] qtr_tab_t [QTR_SIZE];

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x2) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (k[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        return unsigned'(sum);
    endfunction

    function automatic logic [MAG_W-1:0] sine_mag(input int q);
        logic [63:0] s;
        logic [63:0] v;
        s = sin_q30((HALF_PI_Q30 * 64'(q)) / QTR_SIZE);
        v = (s * SINE_PEAK_Q + 64'd536870912) >> 30;
        return MAG_W'(v);
    endfunction

    function automatic qtr_tab_t build_qtr();
        qtr_tab_t t;
        for (int i = 0; i < QTR_SIZE; i++)
        begin
            t[i] = sine_mag(i);
        end
        return t;
    endfunction

    localparam qtr_tab_t         SINE_QTR  = build_qtr();
    localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(QTR_SIZE);

    function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
        input logic [TABLE_BITS-1:0] idx
    );
        logic [QTR_BITS-1:0]        r;
        logic [MAG_W-1:0]           mag;
        logic signed [SAMPLE_W-1:0] v;
        r = idx[QTR_BITS-1:0];
        if (idx[QTR_BITS])
            mag = (r == '0) ? SINE_PEAK : SINE_QTR[QTR_BITS'('0 - r)];
        else
            mag = SINE_QTR[r];
        v = signed'({1'b0, mag});
        return idx[QTR_BITS+1] ? -v : v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] abs16(input logic signed [SAMPLE_W-1:0] s);
        return s[SAMPLE_W-1] ? SAMPLE_W'('0 - unsigned'(s)) : unsigned'(s);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic [MUL_P_W-1:0] p,
        input logic               neg,
        input logic [4:0]         sh
    );
        logic [MUL_P_W:0]           t;
        logic [MUL_P_W:0]           r;
        logic signed [SAMPLE_W-1:0] res;
        t = {1'b0, p} + ((MUL_P_W + 1)'(1) << (sh - 5'd1));
        r = t >> sh;
        if (neg)
        begin
            if (r > (MUL_P_W + 1)'(32768))
                res = 16'sh8000;
            else
                res = signed'(SAMPLE_W'(SAMPLE_W'(0) - r[SAMPLE_W-1:0]));
        end
        else
        begin
            if (r > (MUL_P_W + 1)'(32767))
                res = 16'sh7fff;
            else
                res = signed'(r[SAMPLE_W-1:0]);
        end
        return res;
    endfunction

endpackage

[src/bts_tick_if.sv]
// ----------------------------------------------------------------------------
// bts_tick_if
// Frame request channel: a transaction with tick set asks for one stereo frame.
// ----------------------------------------------------------------------------
interface bts_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

[src/bts_sample_if.sv]
// ----------------------------------------------------------------------------
// bts_sample_if
// Sample channel: one transaction carries one left/right sample pair.
// ----------------------------------------------------------------------------
interface bts_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

[src/beat_tone_synthesizer.sv]
// ----------------------------------------------------------------------------
// beat_tone_synthesizer
// Stereo beat tone generator with binaural, monaural and isochronic modes.
// ----------------------------------------------------------------------------
// One frame request with tick set yields one left/right sample pair. The work
// of a frame runs on a shared bit-serial multiplier and a shared bit-serial
// divider. Silent mode uses neither; binaural mode takes two products and
// monaural mode one; isochronic mode takes two products outside the pulse,
// one division and two products on the flat top of the pulse, and two
// divisions and four products on a ramp. A new request is taken once the
// previous frame has moved into the output register.
module beat_tone_synthesizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bts_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    bts_tick_if.sink                       req,
    bts_sample_if.source                   smp
);
    import bts_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_MUL_MONO,
        ST_DIV_EDGE,
        ST_DIV_X,
        ST_MUL_SQ,
        ST_MUL_SMOOTH,
        ST_MUL_GAIN,
        ST_MUL_OUT,
        ST_FINISH
    } state_t;

    cfg_t     cfg;
    logic     cfg_wr;
    mul_req_t mul_req_reg;
    mul_rsp_t mul_rsp;
    div_req_t div_req_reg;
    div_rsp_t div_rsp;

    state_t                     state_reg;
    logic [PHASE_W-1:0]         phase_l_reg;
    logic [PHASE_W-1:0]         phase_r_reg;
    logic [PHASE_W-1:0]         pulse_reg;
    logic [PHASE_W-1:0]         pos_reg;
    logic signed [SAMPLE_W-1:0] sl_reg;
    logic signed [SAMPLE_W-1:0] sr_reg;
    logic                       mono_neg_reg;
    logic [16:0]                x_reg;
    logic signed [SAMPLE_W-1:0] res_l_reg;
    logic signed [SAMPLE_W-1:0] res_r_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;
    logic                       out_valid_reg;

    logic [PHASE_W-1:0]         half_signed;
    logic [PHASE_W-1:0]         beat_mag;
    logic [PHASE_W-1:0]         half_mag;
    logic [PHASE_W-1:0]         pulse_next;
    logic [PHASE_W:0]           duty_p;
    logic [PHASE_W:0]           pos_ext;
    logic [DIV_N_W-1:0]         edge_num;
    logic signed [SAMPLE_W-1:0] sine_l;
    logic signed [SAMPLE_W-1:0] sine_r;
    logic signed [SAMPLE_W:0]   mono_sum;
    logic [SAMPLE_W:0]          mono_mag;

    bts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    bts_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req_reg),
        .rsp   (mul_rsp)
    );

    bts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign half_signed = {cfg.beat[PHASE_W-1], cfg.beat[PHASE_W-1:1]};
    assign beat_mag    = cfg.beat[PHASE_W-1] ? PHASE_W'('0 - unsigned'(cfg.beat))
                                             : unsigned'(cfg.beat);
    assign half_mag    = beat_mag >> 1;
    assign pulse_next  = pulse_reg + beat_mag;
    assign duty_p      = {cfg.duty, 16'b0};
    assign pos_ext     = {1'b0, pos_reg};
    assign edge_num    = DIV_N_W'({duty_p, 4'b0}) - DIV_N_W'(duty_p);

    assign sine_l   = sine_lookup(phase_l_reg[PHASE_W-1 -: TABLE_BITS]);
    assign sine_r   = sine_lookup(phase_r_reg[PHASE_W-1 -: TABLE_BITS]);
    assign mono_sum = (SAMPLE_W + 1)'(sine_l) + (SAMPLE_W + 1)'(sine_r);
    assign mono_mag = mono_sum[SAMPLE_W] ? (SAMPLE_W + 1)'('0 - unsigned'(mono_sum))
                                         : unsigned'(mono_sum);

    assign req.ready        = (state_reg == ST_IDLE);
    assign smp.valid        = out_valid_reg;
    assign smp.left_sample  = left_reg;
    assign smp.right_sample = right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_l_reg       <= '0;
            phase_r_reg       <= '0;
            pulse_reg         <= '0;
            out_valid_reg     <= 1'b0;
            mul_req_reg.start <= 1'b0;
            div_req_reg.start <= 1'b0;
        end
        else
        begin
            mul_req_reg.start <= 1'b0;
            div_req_reg.start <= 1'b0;
            if (smp.valid && smp.ready)
                out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                phase_l_reg <= '0;
                phase_r_reg <= '0;
                pulse_reg   <= '0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid && req.tick)
                    begin
                        sl_reg       <= sine_l;
                        sr_reg       <= sine_r;
                        mono_neg_reg <= mono_sum[SAMPLE_W];
                        case (cfg.mode)
                            MODE_BINAURAL:
                            begin
                                phase_l_reg <= phase_l_reg + cfg.carrier + half_signed;
                                phase_r_reg <= phase_r_reg + cfg.carrier - half_signed;
                                mul_req_reg <= '{1'b1, MUL_A_W'(cfg.amp),
                                                 MUL_B_W'(abs16(sine_l))};
                                state_reg   <= ST_MUL_L;
                            end
                            MODE_MONAURAL:
                            begin
                                phase_l_reg <= phase_l_reg + cfg.carrier - half_mag;
                                phase_r_reg <= phase_r_reg + cfg.carrier + half_mag;
                                mul_req_reg <= '{1'b1, MUL_A_W'(cfg.amp), MUL_B_W'(mono_mag)};
                                state_reg   <= ST_MUL_MONO;
                            end
                            MODE_ISOCHRONIC:
                            begin
                                phase_l_reg <= phase_l_reg + cfg.carrier;
                                pulse_reg   <= pulse_next;
                                pos_reg     <= pulse_next;
                                if ({1'b0, pulse_next} >= duty_p)
                                begin
                                    mul_req_reg <= '{1'b1, '0, MUL_B_W'(cfg.amp)};
                                    state_reg   <= ST_MUL_GAIN;
                                end
                                else
                                begin
                                    div_req_reg <= '{1'b1, edge_num, PERCENT};
                                    state_reg   <= ST_DIV_EDGE;
                                end
                            end
                            default:
                            begin
                                res_l_reg <= '0;
                                res_r_reg <= '0;
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_MUL_L:
                begin
                    if (mul_rsp.done)
                    begin
                        res_l_reg   <= round_sat(mul_rsp.prod, sl_reg[SAMPLE_W-1], 5'd15);
                        mul_req_reg <= '{1'b1, MUL_A_W'(cfg.amp), MUL_B_W'(abs16(sr_reg))};
                        state_reg   <= ST_MUL_R;
                    end
                end
                ST_MUL_R:
                begin
                    if (mul_rsp.done)
                    begin
                        res_r_reg <= round_sat(mul_rsp.prod, sr_reg[SAMPLE_W-1], 5'd15);
                        state_reg <= ST_FINISH;
                    end
                end
                ST_MUL_MONO:
                begin
                    if (mul_rsp.done)
                    begin
                        res_l_reg <= round_sat(mul_rsp.prod, mono_neg_reg, 5'd16);
                        res_r_reg <= round_sat(mul_rsp.prod, mono_neg_reg, 5'd16);
                        state_reg <= ST_FINISH;
                    end
                end
                ST_DIV_EDGE:
                begin
                    if (div_rsp.done)
                    begin
                        if (pos_ext < div_rsp.quot)
                        begin
                            div_req_reg <= '{1'b1, DIV_N_W'({pos_reg, 16'b0}), div_rsp.quot};
                            state_reg   <= ST_DIV_X;
                        end
                        else if (pos_ext > duty_p - div_rsp.quot)
                        begin
                            div_req_reg <= '{1'b1, DIV_N_W'({duty_p - pos_ext, 16'b0}),
                                             div_rsp.quot};
                            state_reg   <= ST_DIV_X;
                        end
                        else
                        begin
                            mul_req_reg <= '{1'b1, MUL_A_W'(ENV_ONE), MUL_B_W'(cfg.amp)};
                            state_reg   <= ST_MUL_GAIN;
                        end
                    end
                end
                ST_DIV_X:
                begin
                    if (div_rsp.done)
                    begin
                        x_reg       <= div_rsp.quot[16:0];
                        mul_req_reg <= '{1'b1, MUL_A_W'(div_rsp.quot[16:0]),
                                         MUL_B_W'(div_rsp.quot[16:0])};
                        state_reg   <= ST_MUL_SQ;
                    end
                end
                ST_MUL_SQ:
                begin
                    if (mul_rsp.done)
                    begin
                        mul_req_reg <= '{1'b1, MUL_A_W'(SMOOTH_K - {x_reg, 1'b0}),
                                         MUL_B_W'(mul_rsp.prod[31:16])};
                        state_reg   <= ST_MUL_SMOOTH;
                    end
                end
                ST_MUL_SMOOTH:
                begin
                    if (mul_rsp.done)
                    begin
                        mul_req_reg <= '{1'b1, MUL_A_W'(mul_rsp.prod[32:16]),
                                         MUL_B_W'(cfg.amp)};
                        state_reg   <= ST_MUL_GAIN;
                    end
                end
                ST_MUL_GAIN:
                begin
                    if (mul_rsp.done)
                    begin
                        mul_req_reg <= '{1'b1, mul_rsp.prod[MUL_A_W-1:0],
                                         MUL_B_W'(abs16(sl_reg))};
                        state_reg   <= ST_MUL_OUT;
                    end
                end
                ST_MUL_OUT:
                begin
                    if (mul_rsp.done)
                    begin
                        res_l_reg <= round_sat(mul_rsp.prod, sl_reg[SAMPLE_W-1], 5'd31);
                        res_r_reg <= round_sat(mul_rsp.prod, sl_reg[SAMPLE_W-1], 5'd31);
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || smp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        left_reg      <= res_l_reg;
                        right_reg     <= res_r_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[src/bts_regs.sv]
// ----------------------------------------------------------------------------
// bts_regs
// APB register file. Amplitude and duty saturate on write, and every write to
// a mapped register flags the datapath to clear its phases.
// ----------------------------------------------------------------------------
module bts_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bts_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output bts_pkg::cfg_t                  cfg,
    output logic                           cfg_wr
);
    import bts_pkg::*;

    cfg_t        cfg_reg;
    reg_idx_t    idx;
    logic        wr_en;
    logic        idx_ok;
    logic [15:0] amp_sat;
    logic [16:0] duty_sat;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign cfg_wr = wr_en && idx_ok;

    assign amp_sat  = (pwdata[15:0] > AMP_MAX) ? AMP_MAX : pwdata[15:0];
    assign duty_sat = (pwdata[16:0] < DUTY_MIN) ? DUTY_MIN :
                      (pwdata[16:0] > DUTY_MAX) ? DUTY_MAX : pwdata[16:0];

    always_comb
    begin
        idx_ok = 1'b1;
        prdata = '0;
        case (idx)
            REG_MODE:    prdata = APB_DATA_W'(cfg_reg.mode);
            REG_CARRIER: prdata = cfg_reg.carrier;
            REG_BEAT:    prdata = unsigned'(cfg_reg.beat);
            REG_AMP:     prdata = APB_DATA_W'(cfg_reg.amp);
            REG_DUTY:    prdata = APB_DATA_W'(cfg_reg.duty);
            default:     idx_ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{MODE_SILENT, CARRIER_RST, signed'(BEAT_RST), AMP_RST, DUTY_RST};
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MODE:    cfg_reg.mode    <= mode_t'(pwdata[1:0]);
                REG_CARRIER: cfg_reg.carrier <= pwdata;
                REG_BEAT:    cfg_reg.beat    <= signed'(pwdata);
                REG_AMP:     cfg_reg.amp     <= amp_sat;
                REG_DUTY:    cfg_reg.duty    <= duty_sat;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

endmodule

[src/bts_mul.sv]
// ----------------------------------------------------------------------------
// bts_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bts_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  bts_pkg::mul_req_t req,
    output bts_pkg::mul_rsp_t rsp
);
    import bts_pkg::*;

    logic [MUL_P_W-1:0]   acc_reg;
    logic [MUL_P_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                acc_reg  <= '0;
                a_reg    <= MUL_P_W'(req.a);
                b_reg    <= req.b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (b_reg[0])
                    acc_reg <= acc_reg + a_reg;
                a_reg   <= a_reg << 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[src/bts_div.sv]
// ----------------------------------------------------------------------------
// bts_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bts_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bts_pkg::div_req_t req,
    output bts_pkg::div_rsp_t rsp
);
    import bts_pkg::*;

    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W:0]     rem_reg;
    logic [DIV_D_W-1:0]   quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    assign trial    = {rem_reg[DIV_D_W-1:0], num_reg[DIV_N_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                quot_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? (trial - {1'b0, den_reg}) : trial;
                quot_reg <= {quot_reg[DIV_D_W-2:0], fits};
                num_reg  <= num_reg << 1;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the beat tone synthesizer against a cycle-free predictor of its
// sample arithmetic. Registers are written over APB while the block is idle.
// Frame requests are sent in directed and random phases with random gaps on
// both channels. Every returned sample pair is compared with the prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } frame_t;

    class tone_scoreboard;
        mode_t           mode;
        bit [31:0]       carrier;
        bit [31:0]       beat;
        bit [15:0]       amp;
        bit [16:0]       duty;
        bit [31:0]       phase_l;
        bit [31:0]       phase_r;
        bit [31:0]       pulse_pos;
        longint          wave [1024];
        frame_t          frames_due [$];
        int              errors;

        function new();
            longint unsigned s;
            longint unsigned v;
            int              quad;
            int              r;
            int              q;
            for (int i = 0; i < 1024; i++)
            begin
                quad = i / 256;
                r    = i % 256;
                q    = quad[0] ? 256 - r : r;
                s    = quarter_sine((64'd1686629713 * q) / 256);
                v    = (s * 64'd32767 + 64'd536870912) >> 30;
                wave[i] = (quad >= 2) ? -longint'(v) : longint'(v);
            end
            mode      = MODE_SILENT;
            carrier   = CARRIER_RST;
            beat      = BEAT_RST;
            amp       = AMP_RST;
            duty      = DUTY_RST;
            phase_l   = '0;
            phase_r   = '0;
            pulse_pos = '0;
            errors    = 0;
        endfunction

        function longint unsigned quarter_sine(longint unsigned x);
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 6; k++)
            begin
                term = (term * x2) >> 30;
                term = term / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            if (acc > 64'sd1073741824)
                acc = 64'sd1073741824;
            return longint'(acc);
        endfunction

        function logic signed [15:0] scale(longint s, longint unsigned gain, int sh);
            longint unsigned m;
            longint unsigned r;
            m = (s < 0) ? longint'(-s) : longint'(s);
            r = (m * gain + (64'd1 << (sh - 1))) >> sh;
            if (s < 0)
            begin
                if (r > 32768)
                    r = 32768;
                return 16'(64'd0 - r);
            end
            if (r > 32767)
                r = 32767;
            return 16'(r);
        endfunction

        function longint unsigned smooth(longint unsigned x);
            longint unsigned x2;
            x2 = (x * x) >> 16;
            return (x2 * (64'd196608 - 2 * x)) >> 16;
        endfunction

        function void write_reg(int idx, bit [31:0] value);
            bit [16:0] d;
            case (idx)
                REG_MODE:    mode = mode_t'(value[1:0]);
                REG_CARRIER: carrier = value;
                REG_BEAT:    beat = value;
                REG_AMP:     amp = (value[15:0] > AMP_MAX) ? AMP_MAX : value[15:0];
                REG_DUTY:
                begin
                    d = value[16:0];
                    if (d < DUTY_MIN)
                        d = DUTY_MIN;
                    if (d > DUTY_MAX)
                        d = DUTY_MAX;
                    duty = d;
                end
                default: return;
            endcase
            phase_l   = '0;
            phase_r   = '0;
            pulse_pos = '0;
        endfunction

        function void note_tick(bit tick);
            frame_t          f;
            bit [31:0]       bmag;
            bit [31:0]       hb;
            longint unsigned gain;
            longint unsigned duty_p;
            longint unsigned edge_len;
            longint unsigned pos;
            longint unsigned env;
            longint          s;
            if (!tick)
                return;
            bmag = beat[31] ? 32'd0 - beat : beat;
            gain = longint'(amp) * 65536;
            f.left  = '0;
            f.right = '0;
            case (mode)
                MODE_BINAURAL:
                begin
                    hb = (beat >> 1) | (beat & 32'h8000_0000);
                    f.left  = scale(wave[phase_l >> 22], gain, 31);
                    f.right = scale(wave[phase_r >> 22], gain, 31);
                    phase_l = phase_l + carrier + hb;
                    phase_r = phase_r + carrier - hb;
                end
                MODE_MONAURAL:
                begin
                    s = wave[phase_l >> 22] + wave[phase_r >> 22];
                    f.left  = scale(s, gain, 32);
                    f.right = f.left;
                    phase_l = phase_l + carrier - (bmag >> 1);
                    phase_r = phase_r + carrier + (bmag >> 1);
                end
                MODE_ISOCHRONIC:
                begin
                    s         = wave[phase_l >> 22];
                    duty_p    = longint'(duty) << 16;
                    edge_len  = duty_p * 15 / 100;
                    phase_l   = phase_l + carrier;
                    pulse_pos = pulse_pos + bmag;
                    pos       = pulse_pos;
                    env       = 0;
                    if (pos < duty_p)
                    begin
                        if (edge_len != 0 && pos < edge_len)
                            env = smooth((pos << 16) / edge_len);
                        else if (edge_len != 0 && pos > duty_p - edge_len)
                            env = smooth(((duty_p - pos) << 16) / edge_len);
                        else
                            env = 65536;
                    end
                    f.left  = scale(s, longint'(amp) * env, 31);
                    f.right = f.left;
                end
                default: ;
            endcase
            frames_due.push_back(f);
        endfunction

        function void check(logic signed [15:0] left, logic signed [15:0] right);
            frame_t f;
            if (frames_due.size() == 0)
            begin
                $error("unexpected sample pair %0d/%0d", left, right);
                errors++;
                return;
            end
            f = frames_due.pop_front();
            if (left !== f.left)
            begin
                $error("left_sample: expected %0d, actual %0d", f.left, left);
                errors++;
            end
            if (right !== f.right)
            begin
                $error("right_sample: expected %0d, actual %0d", f.right, right);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bts_tick_if   req_ch ();
    bts_sample_if smp_ch ();

    tone_scoreboard sb = new();
    int             ticks_sent;
    int             frames_seen;

    beat_tone_synthesizer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .smp     (smp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    task automatic write_reg(int idx, bit [31:0] value);
        while (sb.frames_due.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_ticks(int count, int zero_pct);
        int gap;
        int r;
        bit t;
        for (int i = 0; i < count; i++)
        begin
            t = ($urandom_range(0, 99) >= zero_pct);
            req_ch.valid <= 1'b1;
            req_ch.tick  <= t;
            do
                @(posedge clk);
            while (!req_ch.ready);
            sb.note_tick(t);
            ticks_sent++;
            r   = $urandom_range(0, 19);
            gap = (r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int r;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        req_ch.valid <= 1'b0;
        req_ch.tick  <= 1'b0;
        ticks_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ticks(2, 0);
        send_ticks(1, 100);
        write_reg(REG_MODE, {30'h3fff_fffc, MODE_BINAURAL});
        send_ticks(3, 0);
        write_reg(REG_CARRIER, 32'h8000_0000);
        write_reg(REG_BEAT, 32'h8000_0000);
        write_reg(REG_AMP, 32'hffff_ffff);
        send_ticks(3, 0);
        write_reg(REG_MODE, {30'd0, MODE_MONAURAL});
        write_reg(REG_CARRIER, 32'hffff_ffff);
        send_ticks(3, 0);
        write_reg(REG_BEAT, 32'h7fff_ffff);
        write_reg(REG_CARRIER, 32'd0);
        send_ticks(2, 0);
        write_reg(REG_MODE, {30'd0, MODE_ISOCHRONIC});
        write_reg(REG_CARRIER, 32'd19478309);
        write_reg(REG_BEAT, 32'hfc00_0000);
        write_reg(REG_DUTY, 32'h0001_ffff);
        send_ticks(5, 0);
        write_reg(REG_DUTY, 32'd0);
        write_reg(REG_BEAT, 32'd0);
        send_ticks(2, 0);
        write_reg(REG_AMP, 32'd0);
        write_reg(REG_DUTY + 1, $urandom);
        send_ticks(2, 0);

        while (ticks_sent < 850)
        begin
            for (int idx = REG_MODE; idx <= REG_DUTY + 1; idx++)
            begin
                if ($urandom_range(0, 2) != 0 && idx != REG_MODE)
                    continue;
                r = $urandom_range(0, 3);
                case (idx)
                    REG_MODE:
                        write_reg(idx, {30'($urandom_range(0, 32'h3fff_ffff)), 2'(r)});
                    REG_CARRIER:
                        write_reg(idx, (r == 0) ? $urandom : $urandom_range(0, 32'h0800_0000));
                    REG_BEAT:
                        if (r == 0)
                            write_reg(idx, $urandom);
                        else
                            write_reg(idx, ($urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff)
                                           ^ $urandom_range(32'h0040_0000, 32'h1000_0000));
                    REG_AMP:
                        write_reg(idx, (r == 0) ? $urandom : $urandom_range(0, 32768));
                    REG_DUTY:
                        write_reg(idx, (r == 0) ? $urandom : $urandom_range(0, 32'h1_ffff));
                    default:
                        write_reg(idx, $urandom);
                endcase
            end
            send_ticks($urandom_range(20, 70), 8);
        end

        while (sb.frames_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        int  r;
        bit  held;
        held = 1'b0;
        smp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && frames_seen >= 100)
            begin
                held = 1'b1;
                smp_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                smp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                smp_ch.ready <= 1'b0;
                repeat ((r == 9) ? $urandom_range(20, 60) : $urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    initial
    begin
        frames_seen = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && smp_ch.valid && smp_ch.ready)
        begin
            sb.check(smp_ch.left_sample, smp_ch.right_sample);
            frames_seen++;
        end
    end

endmodule
